/* rtl/pds_pkg.sv */
// ----------------------------------------------------------------------------
// pds_pkg: shared types and constants of the PLL divider search
// Reference clock, range limits and the beat records that pass between stages.
// ----------------------------------------------------------------------------
package pds_pkg;

    localparam logic [23:0] REF_HZ    = 24'd14318180;
    localparam logic [17:0] MAX_KHZ   = 18'd135000;
    localparam logic [17:0] MIN_KHZ   = 18'd25000;
    localparam logic [9:0]  TGT_SCALE = 10'd1000;
    localparam int          NUM_STEPS = 5;
    localparam int          MAX_QUOT  = 9;

    // Postscaler candidates, last one that fits wins.
    localparam logic [3:0] POST_STEPS [NUM_STEPS] = '{4'd2, 4'd3, 4'd4, 4'd6, 4'd8};

    // Prepared job: scaled target split as q*REF_HZ + r.
    typedef struct packed {
        logic        bad;
        logic [3:0]  post;
        logic [3:0]  q;
        logic [23:0] r;
    } t_job;

    // Running floor(target*d/REF_HZ) and its remainder.
    typedef struct packed {
        logic [8:0]  n;
        logic [23:0] rem;
    } t_trial;

    // Best candidate so far; err is scaled by den.
    typedef struct packed {
        logic        found;
        logic [24:0] err;
        logic [5:0]  den;
        logic [7:0]  num;
        logic [1:0]  dv;
    } t_best;

    typedef struct packed {
        logic       status;
        logic [7:0] numerator;
        logic [5:0] denominator;
        logic [1:0] divider;
        logic [3:0] postscaler;
        logic [7:0] pll_byte_one;
        logic [7:0] pll_byte_two;
        logic       post_high_bit;
    } t_result;

    // k * REF_HZ for the quotient split.
    function automatic logic [27:0] ref_mult(input logic [3:0] k);
        logic [27:0] v;
        v = 28'(k) * 28'(REF_HZ);
        return v;
    endfunction

endpackage

/* rtl/pds_if.sv */
// ----------------------------------------------------------------------------
// pds_if: valid/ready channels of the PLL divider search
// Request channel carries the wanted clock, result channel the settings.
// ----------------------------------------------------------------------------
interface pds_in_if;
    logic        valid;
    logic        ready;
    logic [17:0] clock_khz;
    modport source (output valid, output clock_khz, input ready);
    modport sink   (input valid, input clock_khz, output ready);
endinterface

interface pds_out_if;
    logic       valid;
    logic       ready;
    logic       status;
    logic [7:0] numerator;
    logic [5:0] denominator;
    logic [1:0] divider;
    logic [3:0] postscaler;
    logic [7:0] pll_byte_one;
    logic [7:0] pll_byte_two;
    logic       post_high_bit;
    modport source (output valid, output status, output numerator, output denominator,
                    output divider, output postscaler, output pll_byte_one,
                    output pll_byte_two, output post_high_bit, input ready);
    modport sink   (input valid, input status, input numerator, input denominator,
                    input divider, input postscaler, input pll_byte_one,
                    input pll_byte_two, input post_high_bit, output ready);
endinterface

/* rtl/pds_prep.sv */
// ----------------------------------------------------------------------------
// pds_prep: range check, postscaler pick and target split
// Three stages: khz*P, times 1000, then quotient/remainder by REF_HZ.
// ----------------------------------------------------------------------------
module pds_prep (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [17:0]       i_khz,
    output logic              o_valid,
    output pds_pkg::t_job     o_job
);
    import pds_pkg::*;

    logic [2:0]  r_valid;
    logic        r_bad1, r_bad2;
    logic [3:0]  r_post1, r_post2;
    logic [17:0] r_kp;
    logic [27:0] r_tgt;
    t_job        r_job;

    logic [3:0]  n_post;
    logic [20:0] n_kp;
    logic [3:0]  n_q;

    always_comb begin
        n_post = 4'd1;
        for (int i = 0; i < NUM_STEPS; i++) begin
            if (21'(i_khz) * 21'(POST_STEPS[i]) < 21'(MAX_KHZ)) begin
                n_post = POST_STEPS[i];
            end
        end
        n_kp = 21'(i_khz) * 21'(n_post);
    end

    always_comb begin
        n_q = '0;
        for (int k = 1; k <= MAX_QUOT; k++) begin
            if (r_tgt >= ref_mult(4'(k))) begin
                n_q = 4'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bad1     <= (i_khz < MIN_KHZ) || (i_khz > MAX_KHZ);
            r_post1    <= n_post;
            r_kp       <= n_kp[17:0];
            r_bad2     <= r_bad1;
            r_post2    <= r_post1;
            r_tgt      <= 28'(r_kp) * 28'(TGT_SCALE);
            r_job.bad  <= r_bad2;
            r_job.post <= r_post2;
            r_job.q    <= n_q;
            r_job.r    <= 24'(r_tgt - ref_mult(n_q));
        end
    end

    assign o_valid = r_valid[2];
    assign o_job   = r_job;

endmodule

/* rtl/pds_cell.sv */
// ----------------------------------------------------------------------------
// pds_cell: one denominator step of the search chain
// Advances floor(target*D/REF) and scores the candidate for D-1.
// ----------------------------------------------------------------------------
module pds_cell #(
    parameter int D = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  pds_pkg::t_job     i_job,
    input  pds_pkg::t_trial   i_trial,
    input  pds_pkg::t_best    i_best,
    output logic              o_valid,
    output pds_pkg::t_job     o_job,
    output pds_pkg::t_trial   o_trial,
    output pds_pkg::t_best    o_best
);
    import pds_pkg::*;

    localparam logic [5:0] CD = 6'(D - 1);

    logic        r_valid;
    t_job        r_job;
    t_trial      r_trial;
    t_best       r_best;

    logic [24:0] rem_sum;
    logic        carry;
    t_trial      n_trial;

    logic        big;
    logic [7:0]  c_num;
    logic [24:0] c_err;
    logic [30:0] lhs, rhs;
    t_best       n_best;

    // Step from d-1 to d: add target once more.
    always_comb begin
        rem_sum     = 25'(i_trial.rem) + 25'(i_job.r);
        carry       = rem_sum >= 25'(REF_HZ);
        n_trial.rem = carry ? 24'(rem_sum - 25'(REF_HZ)) : rem_sum[23:0];
        n_trial.n   = i_trial.n + 9'(i_job.q) + 9'(carry);
    end

    // Candidate D-1 is scored from the incoming trial.
    always_comb begin
        big   = i_trial.n > 9'd128;
        c_num = big ? i_trial.n[8:1] : i_trial.n[7:0];
        c_err = 25'(i_trial.rem) + ((big && i_trial.n[0]) ? 25'(REF_HZ) : 25'd0);
        lhs   = 31'(c_err) * 31'(i_best.den);
        rhs   = 31'(i_best.err) * 31'(CD);
        n_best = i_best;
        if (CD >= 6'd2 && (!i_best.found || lhs < rhs)) begin
            n_best.found = 1'b1;
            n_best.err   = c_err;
            n_best.den   = CD;
            n_best.num   = c_num;
            n_best.dv    = big ? 2'd2 : 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_job   <= i_job;
            r_trial <= n_trial;
            r_best  <= n_best;
        end
    end

    assign o_valid = r_valid;
    assign o_job   = r_job;
    assign o_trial = r_trial;
    assign o_best  = r_best;

endmodule

/* rtl/pll_divider_search.sv */
// ----------------------------------------------------------------------------
// pll_divider_search: PLL numerator/denominator search for a pixel clock
// Top level: prep stages, chain of denominator cells, encoder, output buffer.
// ----------------------------------------------------------------------------
// Takes a wanted clock in kHz per beat and returns one result beat with the
// PLL settings (numerator, denominator, divider, postscaler) and the register
// bytes for the selected chip encoding. Requests outside 25000..135000 kHz
// return status 1 with all other fields zero. Throughput is one beat per
// cycle while not stalled; a request passes three prep stages, one cell
// per denominator (each cell also scores the previous denominator, and one
// extra cell scores the last), and the 2-entry output buffer. The pipeline
// only stalls when the last cell holds a beat, the output buffer is full
// and it is not being read. chip_variant is sampled at the encoder, so
// write it only while no request is in flight.
// ----------------------------------------------------------------------------
module pll_divider_search #(
    parameter int MAX_DENOMINATOR = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    pds_in_if.sink        i_item,
    pds_out_if.source     o_result
);
    import pds_pkg::*;

    // one cell per denominator 2..MAX, plus one to score the last
    localparam int NCELL = MAX_DENOMINATOR;

    logic    r_chip_variant;
    logic    en;

    logic    v_c   [NCELL+1];
    t_job    job_c [NCELL+1];
    t_trial  tr_c  [NCELL+1];
    t_best   bst_c [NCELL+1];

    // output buffer
    t_result r_buf [2];
    logic    r_wp, r_rp;
    logic [1:0] r_cnt;
    logic    wr, rd;
    t_result res;

    logic [3:0] pm1;
    logic [2:0] code;
    logic       high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chip_variant <= 1'b0;
        end else if (i_cfg_we) begin
            r_chip_variant <= i_cfg_wdata;
        end
    end

    // advance unless the last cell would overflow a full buffer
    assign en           = !v_c[NCELL] || (r_cnt != 2'd2) || o_result.ready;
    assign i_item.ready = en;

    pds_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_item.valid),
        .i_khz   (i_item.clock_khz),
        .o_valid (v_c[0]),
        .o_job   (job_c[0])
    );

    // d = 1 seed: n = q, rem = r
    assign tr_c[0]  = '{n: 9'(job_c[0].q), rem: job_c[0].r};
    assign bst_c[0] = '0;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        pds_cell #(.D(g + 2)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v_c[g]),
            .i_job   (job_c[g]),
            .i_trial (tr_c[g]),
            .i_best  (bst_c[g]),
            .o_valid (v_c[g+1]),
            .o_job   (job_c[g+1]),
            .o_trial (tr_c[g+1]),
            .o_best  (bst_c[g+1])
        );
    end

    // register byte encoding
    always_comb begin
        pm1 = job_c[NCELL].post - 4'd1;
        if (r_chip_variant) begin
            code = (job_c[NCELL].post == 4'd6) ? 3'd6 : pm1[2:0];
            high = 1'b0;
        end else begin
            code = {1'b0, pm1[1:0]};
            high = pm1[2];
        end
        res = '0;
        if (job_c[NCELL].bad) begin
            res.status = 1'b1;
        end else begin
            res.numerator     = bst_c[NCELL].num;
            res.denominator   = bst_c[NCELL].den;
            res.divider       = bst_c[NCELL].dv;
            res.postscaler    = job_c[NCELL].post;
            res.pll_byte_one  = {bst_c[NCELL].dv == 2'd2, 7'(bst_c[NCELL].num - 8'd1)};
            res.pll_byte_two  = {code, 5'(bst_c[NCELL].den - 6'd1)};
            res.post_high_bit = high;
        end
    end

    assign wr = en && v_c[NCELL];
    assign rd = o_result.valid && o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= !r_wp;
            if (rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_buf[r_wp] <= res;
        end
    end

    assign o_result.valid         = r_cnt != 2'd0;
    assign o_result.status        = r_buf[r_rp].status;
    assign o_result.numerator     = r_buf[r_rp].numerator;
    assign o_result.denominator   = r_buf[r_rp].denominator;
    assign o_result.divider       = r_buf[r_rp].divider;
    assign o_result.postscaler    = r_buf[r_rp].postscaler;
    assign o_result.pll_byte_one  = r_buf[r_rp].pll_byte_one;
    assign o_result.pll_byte_two  = r_buf[r_rp].pll_byte_two;
    assign o_result.post_high_bit = r_buf[r_rp].post_high_bit;

endmodule

/* rtl/pds_checker.sv */
// ----------------------------------------------------------------------------
// pds_checker: port-level checks of the PLL divider search
// Result consistency and output channel behavior, bound to the top level.
// ----------------------------------------------------------------------------
module pds_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic       i_status,
    input logic [7:0] i_numerator,
    input logic [5:0] i_denominator,
    input logic [1:0] i_divider,
    input logic [7:0] i_byte_one
);

    a_rst_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result valid right after reset");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status |-> i_numerator == 8'd0 && i_denominator == 6'd0
                                && i_divider == 2'd0 && i_byte_one == 8'd0)
        else $error("error beat carries nonzero settings");

    a_ok_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_status |-> i_denominator >= 6'd2
                                 && (i_divider == 2'd1 || i_divider == 2'd2))
        else $error("denominator or divider out of range");

    a_div_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_status |-> i_byte_one[7] == (i_divider == 2'd2))
        else $error("byte one divider bit mismatch");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_numerator))
        else $error("stalled beat dropped or changed");

endmodule

bind pll_divider_search pds_checker u_pds_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_result.valid),
    .i_ready       (o_result.ready),
    .i_status      (o_result.status),
    .i_numerator   (o_result.numerator),
    .i_denominator (o_result.denominator),
    .i_divider     (o_result.divider),
    .i_byte_one    (o_result.pll_byte_one)
);

/* dv/pds_checker.sv */
// ----------------------------------------------------------------------------
// pds_scoreboard: result predictor and scoreboard for the PLL divider search
// Watches both channels, predicts every accepted request, compares results.
// ----------------------------------------------------------------------------
module pds_scoreboard (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    pds_in_if.sink    i_req_mon,
    pds_out_if.sink   i_res_mon,
    output int        o_fail_count,
    output int        o_pending
);
    import pds_pkg::*;

    logic    chip_new;
    t_result settings_q[$];

    // Exact search over all denominators; err scaled by den, compared crosswise.
    function automatic t_result search_settings(input logic [17:0] khz, input logic variant);
        t_result     r;
        logic [3:0]  post;
        logic [63:0] target, num, lhs, rhs, err, best_err, best_den;
        logic [7:0]  best_num;
        logic [5:0]  best_d;
        logic [1:0]  best_dv, dv;
        logic [2:0]  code;
        bit          have;
        int          steps[5];
        r = '0;
        steps = '{2, 3, 4, 6, 8};
        if (khz < MIN_KHZ || khz > MAX_KHZ) begin
            r.status = 1'b1;
            return r;
        end
        post = 4'd1;
        foreach (steps[i]) begin
            if (64'(khz) * steps[i] < 64'(MAX_KHZ)) post = 4'(steps[i]);
        end
        target = 64'(khz) * 1000 * post;
        have = 0;
        best_err = 0;
        best_den = 1;
        best_num = 0;
        best_d = 0;
        best_dv = 0;
        for (int d = 2; d <= 32; d++) begin
            num = (target * d) / 64'(REF_HZ);
            dv = 2'd1;
            if (num > 128) begin
                num = num >> 1;
                dv = 2'd2;
            end
            lhs = target * d;
            rhs = 64'(REF_HZ) * num * dv;
            err = (lhs >= rhs) ? lhs - rhs : rhs - lhs;
            if (!have || err * best_den < best_err * d) begin
                have = 1;
                best_err = err;
                best_den = 64'(d);
                best_num = num[7:0];
                best_dv = dv;
                best_d = 6'(d);
            end
        end
        if (variant) begin
            code = (post == 4'd6) ? 3'd6 : 3'(post - 1);
            r.post_high_bit = 1'b0;
        end else begin
            code = {1'b0, 2'(post - 1)};
            r.post_high_bit = 1'((post - 4'd1) >> 2);
        end
        r.numerator = best_num;
        r.denominator = best_d;
        r.divider = best_dv;
        r.postscaler = post;
        r.pll_byte_one = {best_dv == 2'd2, 7'(best_num - 8'd1)};
        r.pll_byte_two = {code, 5'(best_d - 6'd1)};
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            chip_new <= 1'b0;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) chip_new <= i_cfg_wdata;
            if (i_req_mon.valid && i_req_mon.ready)
                settings_q.push_back(search_settings(i_req_mon.clock_khz, chip_new));
            if (i_res_mon.valid && i_res_mon.ready) begin
                got = '{i_res_mon.status, i_res_mon.numerator, i_res_mon.denominator,
                        i_res_mon.divider, i_res_mon.postscaler, i_res_mon.pll_byte_one,
                        i_res_mon.pll_byte_two, i_res_mon.post_high_bit};
                if (settings_q.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10) $display("unexpected result beat %p", got);
                end else begin
                    want = settings_q.pop_front();
                    if (got !== want) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_fail_count < 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
        end
        o_pending <= settings_q.size();
    end

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench top of the PLL divider search
// Drives requests and chip variant settings; the checker judges the results.
// ----------------------------------------------------------------------------
module tb;
    import pds_pkg::*;

    localparam int LATENCY = 40;
    localparam int CYCLE_LIMIT = 200000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;
    int   fail_count;
    int   pending;
    int   cycles = 0;
    bit   calm;       // no idling in the final part
    bit   hold_off;   // long receiver stall
    bit   sent_all;

    pds_in_if  req_if();
    pds_out_if res_if();

    pll_divider_search dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata), .i_item(req_if.sink), .o_result(res_if.source)
    );

    pds_scoreboard checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata), .i_req_mon(req_if.sink),
        .i_res_mon(res_if.sink), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("pll_divider_search verification failed");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off, none at the end.
    initial begin
        int gap;
        bit held;
        held = 0;
        res_if.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off && !held) begin
                res_if.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                held = 1;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 18);
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // Mostly in-range clocks, some near edges, a few anywhere.
    function automatic logic [17:0] random_clock();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) return 18'($urandom_range(25000, 135000));
        if (pick < 8) return 18'($urandom_range(0, 8) + 24996 + 110000 * $urandom_range(0, 1));
        return 18'($urandom);
    endfunction

    task automatic send_clock(input logic [17:0] khz);
        req_if.valid <= 1'b1;
        req_if.clock_khz <= khz;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic drain_and_set(input logic variant);
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || res_if.valid) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= variant;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        // Directed corners: range edges, every postscaler boundary, extremes.
        logic [17:0] corner[$] = '{18'd0, 18'd24999, 18'd25000, 18'd25001, 18'd33749,
            18'd33750, 18'd45000, 18'd44999, 18'd67499, 18'd67500, 18'd134999,
            18'd135000, 18'd135001, 18'd262143, 18'd16875, 18'd100000, 18'd65000,
            18'd108000, 18'h15555, 18'h2AAAA};
        calm = 0;
        hold_off = 0;
        sent_all = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 1'b0;
        req_if.valid = 1'b0;
        req_if.clock_khz = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Variant stays at its reset value for the first pass.
        foreach (corner[i]) send_clock(corner[i]);
        drain_and_set(1'b1);
        foreach (corner[i]) send_clock(corner[i]);
        for (int phase = 0; phase < 4; phase++) begin
            drain_and_set(phase[0]);
            if (phase == 1) hold_off = 1;
            if (phase == 3) calm = 1;
            repeat (250) send_clock(random_clock());
        end
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || res_if.valid) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("pll_divider_search verification clean");
        end else begin
            $display("pll_divider_search verification failed");
        end
        $finish;
    end

endmodule
